FILE: design/tsre_pkg.sv
package tsre_pkg;

   localparam int FracBitsDefault = 16;
   localparam int DataWidth = 32;
   localparam int HoverWidth = 17;
   localparam int CsrAddrWidth = 4;

   localparam logic [CsrAddrWidth-1:0] AddrHover = 4'h0;
   localparam logic [CsrAddrWidth-1:0] AddrLambda = 4'h4;
   localparam logic [CsrAddrWidth-1:0] AddrCov = 4'h8;

   localparam logic [16:0] HoverReset = 17'd32768;
   localparam logic [16:0] LambdaReset = 17'd64881;
   localparam logic [31:0] CovReset = 32'd65536;

   // 9.8015 scaled by 2^32.
   localparam logic [35:0] GravityQ32 = 36'd42097121952;

   typedef struct packed {
      logic signed [31:0] acceleration;
   } req_type;

   typedef struct packed {
      logic signed [31:0] thrust;
      logic slope_unchanged;
      logic math_fault;
   } rsp_type;

endpackage

FILE: design/tsre_if.sv
interface tsre_req_if;
   import tsre_pkg::*;
   logic valid;
   logic ready;
   logic signed [31:0] acceleration;
   modport source (output valid, output acceleration, input ready);
   modport sink (input valid, input acceleration, output ready);
endinterface

interface tsre_rsp_if;
   import tsre_pkg::*;
   logic valid;
   logic ready;
   logic signed [31:0] thrust;
   logic slope_unchanged;
   logic math_fault;
   modport source (output valid, output thrust, output slope_unchanged, output math_fault,
      input ready);
   modport sink (input valid, input thrust, input slope_unchanged, input math_fault,
      output ready);
endinterface

FILE: design/tsre_div.sv
module tsre_div (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [63:0] num,
   input logic [63:0] den,
   output logic busy,
   output logic [63:0] quo
);
   import tsre_pkg::*;

   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] den_ff, den_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [64:0] trial;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      trial = {rem_ff, quo_ff[63]} - {1'b0, den_ff};
      if (start) begin
         rem_in = '0;
         quo_in = num;
         den_in = den;
         cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         cnt_in = cnt_ff - 7'd1;
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy = (cnt_ff != 7'd0);
   assign quo = quo_ff;
endmodule

FILE: design/thrust_slope_rls_estimator_unit.sv
// Thrust slope estimator: each request carries a commanded acceleration. The block refines its
// thrust-to-acceleration slope with one scalar recursive least squares step with forgetting,
// using the thrust it returned last time, and answers with thrust = acceleration / slope in
// signed fixed point. The first request after reset only divides. Requests are taken one at a
// time while the engine is idle. Products use the 32x32 shift-add multiplier and quotients
// the bit-serial divider. An update has six products and three quotients, and the result is
// then registered. A zero divisor skips its division. Writing the hover level register
// reloads the slope through the divider (a zero level saturates it), and requests are refused
// until the reload is done. Results wait in an output register, so the next request can enter
// while the previous result is pending. A finished result waits until that register is free.
module thrust_slope_rls_estimator_unit #(
   parameter int FRAC_BITS = tsre_pkg::FracBitsDefault
) (
   input logic clock,
   input logic reset,
   tsre_req_if.sink req,
   tsre_rsp_if.source rsp,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [tsre_pkg::CsrAddrWidth-1:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import tsre_pkg::*;

   localparam logic [3:0] StIdle = 4'd0;
   localparam logic [3:0] StMul = 4'd1;
   localparam logic [3:0] StDiv = 4'd2;
   localparam logic [3:0] StNext = 4'd3;
   localparam logic [3:0] StOut = 4'd4;
   localparam logic [3:0] StLoad = 4'd5;
   localparam logic [3:0] StLoadWait = 4'd6;

   // Program steps of the update.
   localparam logic [3:0] OpPt = 4'd0;
   localparam logic [3:0] OpTpt = 4'd1;
   localparam logic [3:0] OpGain = 4'd2;
   localparam logic [3:0] OpTs = 4'd3;
   localparam logic [3:0] OpGe = 4'd4;
   localparam logic [3:0] OpKt = 4'd5;
   localparam logic [3:0] OpOmp = 4'd6;
   localparam logic [3:0] OpCov = 4'd7;
   localparam logic [3:0] OpThrust = 4'd8;

   // What a running division produces.
   localparam logic [1:0] DivGain = 2'd0;
   localparam logic [1:0] DivCov = 2'd1;
   localparam logic [1:0] DivThrust = 2'd2;

   localparam int UpShift = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int DnShift = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam logic [63:0] GravityFrac =
      64'((GravityQ32 + (36'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
   localparam logic signed [65:0] One = 66'sd1 <<< FRAC_BITS;

   logic [16:0] hover_ff;
   logic [16:0] lambda_ff;
   logic [31:0] icov_ff;
   logic signed [31:0] slope_ff, slope_in;
   logic [31:0] cov_ff, cov_in;
   logic signed [31:0] last_ff, last_in;
   logic valid_ff, valid_in;
   logic [3:0] state_ff, state_in;
   logic [3:0] op_ff, op_in;
   logic fault_ff, fault_in;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [31:0] pt_ff, pt_in;
   logic signed [31:0] den_ff, den_in;
   logic signed [31:0] gain_ff, gain_in;
   logic signed [31:0] err_ff, err_in;
   logic signed [31:0] om_ff, om_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Shift-add multiplier on magnitudes, one multiplier bit per cycle.
   logic [63:0] mprod_ff, mprod_in;
   logic [31:0] mcand_ff, mcand_in;
   logic [31:0] mplier_ff, mplier_in;
   logic mneg_ff, mneg_in;
   logic [5:0] mcnt_ff, mcnt_in;
   logic [32:0] msum;

   // Divider operands and sign.
   logic div_start;
   logic [63:0] div_num, div_den, div_quo;
   logic div_busy;
   logic dneg_ff, dneg_in;
   logic [1:0] dkind_ff, dkind_in;

   logic cfg_wr;
   logic signed [65:0] mres, qres, cov_lam;
   logic [63:0] cov_conv;
   logic signed [32:0] ma, mb;
   logic signed [65:0] tmp;

   tsre_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .busy(div_busy), .quo(div_quo)
   );

   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      case (csr_paddr)
         AddrHover: csr_prdata = {15'd0, hover_ff};
         AddrLambda: csr_prdata = {15'd0, lambda_ff};
         AddrCov: csr_prdata = icov_ff;
         default: csr_prdata = '0;
      endcase
   end

   assign cov_conv = ({32'd0, csr_pwdata} << UpShift) >> DnShift;
   assign cov_lam = 66'(({49'd0, lambda_ff} << UpShift) >> DnShift);

   // Signed product floored by FRAC_BITS, and signed quotient.
   always_comb begin
      tmp = mneg_ff ? -$signed({2'b0, mprod_ff}) : $signed({2'b0, mprod_ff});
      mres = tmp >>> FRAC_BITS;
      qres = dneg_ff ? -$signed({2'b0, div_quo}) : $signed({2'b0, div_quo});
   end

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                                 output logic f);
      f = 1'b0;
      if (v > 66'sd2147483647) begin
         f = 1'b1;
         sat32 = 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         f = 1'b1;
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   function automatic logic [31:0] satu(input logic signed [65:0] v, output logic f);
      f = 1'b0;
      if (v < 0) begin
         f = 1'b1;
         satu = '0;
      end else if (v > 66'sd4294967295) begin
         f = 1'b1;
         satu = '1;
      end else begin
         satu = v[31:0];
      end
   endfunction

   always_comb begin
      logic f1, f2;
      logic signed [31:0] s1;
      state_in = state_ff;
      op_in = op_ff;
      fault_in = fault_ff;
      acc_in = acc_ff;
      slope_in = slope_ff;
      cov_in = cov_ff;
      last_in = last_ff;
      valid_in = valid_ff;
      pt_in = pt_ff;
      den_in = den_ff;
      gain_in = gain_ff;
      err_in = err_ff;
      om_in = om_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      mprod_in = mprod_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      mneg_in = mneg_ff;
      mcnt_in = mcnt_ff;
      dneg_in = dneg_ff;
      dkind_in = dkind_ff;
      div_start = 1'b0;
      div_num = '0;
      div_den = '0;
      ma = '0;
      mb = '0;
      f1 = 1'b0;
      f2 = 1'b0;
      s1 = '0;
      msum = {1'b0, mprod_ff[63:32]} + {1'b0, mcand_ff};
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (mcnt_ff != 6'd0) begin
         mcnt_in = mcnt_ff - 6'd1;
         if (mplier_ff[0]) begin
            mprod_in = {msum, mprod_ff[31:1]};
         end else begin
            mprod_in = mprod_ff >> 1;
         end
         mplier_in = mplier_ff >> 1;
      end
      case (state_ff)
         StIdle: begin
            if (req.valid && req.ready) begin
               acc_in = req.acceleration;
               fault_in = 1'b0;
               if (!valid_ff) begin
                  op_in = OpThrust;
                  state_in = StNext;
               end else begin
                  op_in = OpPt;
                  state_in = StNext;
               end
            end
         end
         StLoad: begin
            if (hover_ff == 17'd0) begin
               slope_in = 32'sh7fffffff;
               state_in = StIdle;
            end else begin
               div_start = 1'b1;
               div_num = GravityFrac << 16;
               div_den = {47'd0, hover_ff};
               state_in = StLoadWait;
            end
         end
         StLoadWait: begin
            if (!div_busy) begin
               slope_in = (div_quo > 64'h7fffffff) ? 32'sh7fffffff : div_quo[31:0];
               state_in = StIdle;
            end
         end
         StNext: begin
            // Issue the next arithmetic step.
            case (op_ff)
               OpPt: begin ma = 33'(last_ff); mb = {1'b0, cov_ff}; state_in = StMul; end
               OpTpt: begin ma = 33'(last_ff); mb = 33'(pt_ff); state_in = StMul; end
               OpTs: begin ma = 33'(last_ff); mb = 33'(slope_ff); state_in = StMul; end
               OpGe: begin ma = 33'(gain_ff); mb = 33'(err_ff); state_in = StMul; end
               OpKt: begin ma = 33'(gain_ff); mb = 33'(last_ff); state_in = StMul; end
               OpOmp: begin ma = 33'(om_ff); mb = {1'b0, cov_ff}; state_in = StMul; end
               OpGain: begin
                  if (den_ff == 0) begin
                     gain_in = '0;
                     fault_in = 1'b1;
                     op_in = OpTs;
                  end else begin
                     div_start = 1'b1;
                     div_num = 64'(pt_ff < 0 ? -66'(pt_ff) : 66'(pt_ff)) << FRAC_BITS;
                     div_den = 64'(den_ff < 0 ? -66'(den_ff) : 66'(den_ff));
                     dneg_in = (pt_ff < 0) != (den_ff < 0);
                     dkind_in = DivGain;
                     state_in = StDiv;
                  end
               end
               OpCov: begin
                  if (cov_lam == 0) begin
                     fault_in = 1'b1;
                     cov_in = '1;
                     op_in = OpThrust;
                  end else begin
                     div_start = 1'b1;
                     div_num = {32'd0, cov_ff} << FRAC_BITS;
                     div_den = 64'(cov_lam);
                     dneg_in = 1'b0;
                     dkind_in = DivCov;
                     state_in = StDiv;
                  end
               end
               default: begin
                  if (slope_ff == 0) begin
                     fault_in = 1'b1;
                     s1 = (acc_ff > 0) ? 32'sh7fffffff : (acc_ff < 0) ? 32'sh80000000 : '0;
                     state_in = StOut;
                     last_in = s1;
                  end else begin
                     div_start = 1'b1;
                     div_num = 64'(acc_ff < 0 ? -66'(acc_ff) : 66'(acc_ff)) << FRAC_BITS;
                     div_den = 64'(slope_ff < 0 ? -66'(slope_ff) : 66'(slope_ff));
                     dneg_in = (acc_ff < 0) != (slope_ff < 0);
                     dkind_in = DivThrust;
                     state_in = StDiv;
                  end
               end
            endcase
            if (state_in == StMul) begin
               mneg_in = ma[32] ^ mb[32];
               mcand_in = 32'(ma[32] ? -ma : ma);
               mplier_in = 32'(mb[32] ? -mb : mb);
               mprod_in = '0;
               mcnt_in = 6'd32;
            end
         end
         StMul: begin
            if (mcnt_ff == 6'd0) begin
               state_in = StNext;
               case (op_ff)
                  OpPt: begin
                     pt_in = sat32(mres, f1);
                     op_in = OpTpt;
                  end
                  OpTpt: begin
                     s1 = sat32(mres, f1);
                     den_in = sat32(cov_lam + 66'(s1), f2);
                     op_in = OpGain;
                  end
                  OpTs: begin
                     s1 = sat32(mres, f1);
                     err_in = sat32(66'(acc_ff) - 66'(s1), f2);
                     op_in = OpGe;
                  end
                  OpGe: begin
                     s1 = sat32(mres, f1);
                     slope_in = sat32(66'(slope_ff) + 66'(s1), f2);
                     op_in = OpKt;
                  end
                  OpKt: begin
                     s1 = sat32(mres, f1);
                     om_in = sat32(One - 66'(s1), f2);
                     op_in = OpOmp;
                  end
                  default: begin
                     cov_in = satu(mres, f1);
                     op_in = OpCov;
                  end
               endcase
               fault_in = fault_ff | f1 | f2;
            end
         end
         StDiv: begin
            if (!div_busy && !div_start) begin
               case (dkind_ff)
                  DivGain: begin
                     gain_in = sat32(qres, f1);
                     op_in = OpTs;
                     state_in = StNext;
                  end
                  DivCov: begin
                     cov_in = satu(qres, f1);
                     op_in = OpThrust;
                     state_in = StNext;
                  end
                  default: begin
                     last_in = sat32(qres, f1);
                     state_in = StOut;
                  end
               endcase
               fault_in = fault_ff | f1;
            end
         end
         StOut: begin
            // The result waits here until the output register is free.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_in.thrust = last_ff;
               rsp_in.slope_unchanged = !valid_ff;
               rsp_in.math_fault = fault_ff;
               rsp_valid_in = 1'b1;
               valid_in = 1'b1;
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
      // Register writes must arrive only while no request is being worked on; the block does not enforce this.
      if (cfg_wr && csr_paddr == AddrHover) begin
         state_in = StLoad;
      end
      if (cfg_wr && csr_paddr == AddrCov) begin
         cov_in = (cov_conv > 64'hffffffff) ? 32'hffffffff : cov_conv[31:0];
      end
   end

   assign req.ready = (state_ff == StIdle) && !cfg_wr;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.thrust = rsp_ff.thrust;
   assign rsp.slope_unchanged = rsp_ff.slope_unchanged;
   assign rsp.math_fault = rsp_ff.math_fault;

   always_ff @(posedge clock) begin
      if (reset) begin
         hover_ff <= HoverReset;
         lambda_ff <= LambdaReset;
         icov_ff <= CovReset;
         state_ff <= StLoad;
         op_ff <= OpPt;
         valid_ff <= 1'b0;
         last_ff <= '0;
         cov_ff <= 32'(({32'd0, CovReset} << UpShift) >> DnShift);
         slope_ff <= '0;
         rsp_valid_ff <= 1'b0;
         mcnt_ff <= '0;
         fault_ff <= 1'b0;
      end else begin
         if (cfg_wr && csr_paddr == AddrHover) hover_ff <= csr_pwdata[16:0];
         if (cfg_wr && csr_paddr == AddrLambda) lambda_ff <= csr_pwdata[16:0];
         if (cfg_wr && csr_paddr == AddrCov) icov_ff <= csr_pwdata;
         state_ff <= state_in;
         op_ff <= op_in;
         valid_ff <= valid_in;
         last_ff <= last_in;
         cov_ff <= cov_in;
         slope_ff <= slope_in;
         rsp_valid_ff <= rsp_valid_in;
         mcnt_ff <= mcnt_in;
         fault_ff <= fault_in;
      end
      acc_ff <= acc_in;
      pt_ff <= pt_in;
      den_ff <= den_in;
      gain_ff <= gain_in;
      err_ff <= err_in;
      om_ff <= om_in;
      rsp_ff <= rsp_in;
      mprod_ff <= mprod_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      mneg_ff <= mneg_in;
      dneg_ff <= dneg_in;
      dkind_ff <= dkind_in;
   end

`ifndef SYNTH
   // A result must not be overwritten before it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("pending result lost");
   // A request is only taken with the engine idle.
   assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |-> state_ff == StIdle)
      else $error("request taken while busy");
   // The multiplier runs only in the multiply step.
   assert property (@(posedge clock) disable iff (reset)
      mcnt_ff != 6'd0 |-> state_ff == StMul)
      else $error("multiplier active outside multiply step");
`endif
endmodule

FILE: dv/thrust_slope_rls_estimator_unit_checker.sv
`timescale 1ns / 100ps

module thrust_slope_rls_estimator_unit_checker (
   input logic clock,
   input logic reset,
   tsre_req_if.sink req,
   tsre_rsp_if.sink rsp,
   input logic [16:0] hover_level,
   input logic [16:0] forgetting_factor,
   input logic [31:0] initial_covariance,
   input logic load_hover,
   input logic load_cov,
   output int errors,
   output int pending,
   output int seen_faults,
   output int seen_results
);
   import tsre_pkg::*;

   localparam int Frac = FracBitsDefault;
   localparam longint SMax = 64'sd2147483647;
   localparam longint SMin = -64'sd2147483648;

   logic signed [31:0] slope_q;
   logic [31:0] cov_q;
   logic signed [31:0] prev_thrust;
   logic have_prev;
   logic step_fault;
   rsp_type thrust_queue[$];

   function automatic longint floor_shift(longint v);
      return v >>> Frac;
   endfunction

   function automatic longint clip_s(longint v);
      if (v > SMax) begin
         step_fault = 1'b1;
         return SMax;
      end
      if (v < SMin) begin
         step_fault = 1'b1;
         return SMin;
      end
      return v;
   endfunction

   function automatic longint clip_u(longint v);
      if (v < 0) begin
         step_fault = 1'b1;
         return 0;
      end
      if (v > 64'sh0FFFFFFFF) begin
         step_fault = 1'b1;
         return 64'sh0FFFFFFFF;
      end
      return v;
   endfunction

   function automatic longint qdiv(longint num, longint den);
      if (den == 0) begin
         step_fault = 1'b1;
         if (num > 0) return SMax;
         if (num < 0) return SMin;
         return 0;
      end
      return clip_s((num * (64'sd1 << Frac)) / den);
   endfunction

   function automatic logic signed [31:0] slope_from_hover(logic [16:0] h);
      longint unsigned g;
      longint unsigned q;
      g = (64'd42097121952 + (64'd1 << (31 - Frac))) >> (32 - Frac);
      if (h == 0) return 32'sh7FFFFFFF;
      q = (g << 16) / h;
      return (q > 64'd2147483647) ? 32'sh7FFFFFFF : q[31:0];
   endfunction

   // One estimator step: refine the slope from the previous thrust if there is one, then divide.
   function automatic rsp_type predict_thrust(logic signed [31:0] accel);
      rsp_type r;
      longint a, t, p, lam, pt, tpt, den, gain, err, kt, om, scaled, th;
      a = accel;
      step_fault = 1'b0;
      if (!have_prev) begin
         r.slope_unchanged = 1'b1;
         th = qdiv(a, slope_q);
      end else begin
         r.slope_unchanged = 1'b0;
         t = prev_thrust;
         p = cov_q;
         lam = forgetting_factor;
         pt = clip_s(floor_shift(t * p));
         tpt = clip_s(floor_shift(t * pt));
         den = clip_s(lam + tpt);
         if (den == 0) begin
            step_fault = 1'b1;
            gain = 0;
         end else begin
            gain = qdiv(pt, den);
         end
         err = clip_s(a - clip_s(floor_shift(t * longint'(slope_q))));
         slope_q = 32'(clip_s(longint'(slope_q) + clip_s(floor_shift(gain * err))));
         kt = clip_s(floor_shift(gain * t));
         om = clip_s((64'sd1 << Frac) - kt);
         scaled = clip_u(floor_shift(om * p));
         if (lam == 0) begin
            step_fault = 1'b1;
            cov_q = 32'hFFFFFFFF;
         end else begin
            cov_q = 32'(clip_u((scaled * (64'sd1 << Frac)) / lam));
         end
         th = qdiv(a, slope_q);
      end
      prev_thrust = 32'(th);
      have_prev = 1'b1;
      r.thrust = 32'(th);
      r.math_fault = step_fault;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         slope_q = slope_from_hover(HoverReset);
         cov_q = CovReset;
         prev_thrust = '0;
         have_prev = 1'b0;
         errors <= 0;
         seen_faults <= 0;
         seen_results <= 0;
         thrust_queue.delete();
      end else begin
         if (load_hover) slope_q = slope_from_hover(hover_level);
         if (load_cov) cov_q = initial_covariance;
         if (rsp.valid && rsp.ready) begin
            seen_results <= seen_results + 1;
            if (rsp.math_fault) seen_faults <= seen_faults + 1;
            if (thrust_queue.size() == 0) begin
               errors <= errors + 1;
               if (errors < 10) $display("%0t: unexpected result thrust=%h", $realtime,
                  rsp.thrust);
            end else begin
               want = thrust_queue.pop_front();
               if (rsp.thrust !== want.thrust || rsp.slope_unchanged !== want.slope_unchanged
                     || rsp.math_fault !== want.math_fault) begin
                  errors <= errors + 1;
                  if (errors < 10)
                     $display("%0t: expected thrust=%h unchanged=%b fault=%b, got %h %b %b",
                        $realtime, want.thrust, want.slope_unchanged, want.math_fault,
                        rsp.thrust, rsp.slope_unchanged, rsp.math_fault);
               end
            end
         end
         if (req.valid && req.ready) thrust_queue.push_back(predict_thrust(req.acceleration));
      end
   end

   assign pending = thrust_queue.size();

endmodule

FILE: dv/thrust_slope_rls_estimator_unit_tb.sv
`timescale 1ns / 100ps

module thrust_slope_rls_estimator_unit_tb;
   import tsre_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;
   logic [16:0] hover_level = HoverReset;
   logic [16:0] forgetting_factor = LambdaReset;
   logic [31:0] initial_covariance = CovReset;
   logic load_hover = 1'b0;
   logic load_cov = 1'b0;
   int errors, pending, seen_faults, seen_results;
   int sent = 0;
   int stall_mode = 0;

   tsre_req_if req ();
   tsre_rsp_if rsp ();

   thrust_slope_rls_estimator_unit uut (
      .clock, .reset, .req(req.sink), .rsp(rsp.source),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_prdata, .csr_pready
   );

   thrust_slope_rls_estimator_unit_checker check (
      .clock, .reset, .req(req.sink), .rsp(rsp.sink), .hover_level, .forgetting_factor,
      .initial_covariance, .load_hover, .load_cov, .errors, .pending, .seen_faults,
      .seen_results
   );

   always #5 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.acceleration = '0;
      rsp.ready = 1'b0;
   end

   // The receiver alternates among always ready, light and heavy stalling.
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp.ready <= 1'b1;
         1: rsp.ready <= ($urandom_range(0, 3) != 0);
         default: rsp.ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   task automatic csr_write(logic [CsrAddrWidth-1:0] addr, logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      load_hover <= (addr == AddrHover);
      load_cov <= (addr == AddrCov);
      if (addr == AddrHover) hover_level <= data[16:0];
      if (addr == AddrLambda) forgetting_factor <= data[16:0];
      if (addr == AddrCov) initial_covariance <= data;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      load_hover <= 1'b0;
      load_cov <= 1'b0;
   endtask

   // Ready is sampled at the edge itself, before the block updates.
   task automatic send_accel(logic [31:0] accel);
      req.valid <= 1'b1;
      req.acceleration <= accel;
      @(posedge clock iff req.ready);
      sent++;
   endtask

   task automatic gap();
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   // Accelerations near hover, with occasional extremes and bit noise.
   function automatic logic [31:0] random_accel();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         2: return 32'(int'($urandom_range(0, 40000)) - 20000);
         default: return 32'(int'($urandom_range(0, 1966080)) - 327680 + 655360);
      endcase
   endfunction

   initial begin
      logic [31:0] dir_accel[$] = '{32'h0, 32'h00010000, 32'hFFFF0000, 32'h7FFFFFFF,
         32'h80000000, 32'h0009CD0E, 32'h00000001, 32'hFFFFFFFF, 32'h00140000, 32'h0};
      int burst;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_accel[i]) send_accel(dir_accel[i]);
      drain();
      // Extreme settings: zero hover (slope saturates) and zero forgetting factor.
      csr_write(AddrHover, 32'd0);
      csr_write(AddrLambda, 32'd0);
      csr_write(AddrCov, 32'hFFFFFFFF);
      repeat (6) send_accel(random_accel());
      drain();
      csr_write(AddrHover, 32'd65536);
      csr_write(AddrLambda, 32'd65536);
      csr_write(AddrCov, 32'd1);
      repeat (6) send_accel(random_accel());
      drain();
      for (int phase = 0; phase < 8; phase++) begin
         csr_write(AddrHover, $urandom_range(1, 65536));
         csr_write(AddrLambda, $urandom_range(60000, 65536));
         csr_write(AddrCov, $urandom_range(1, 1 << 20));
         while (sent < 50 + 140 * (phase + 1)) begin
            burst = $urandom_range(1, 12);
            repeat (burst) send_accel(random_accel());
            if ($urandom_range(0, 2) == 0) gap();
         end
         drain();
      end
      $display("Covered %0d requests over eleven register settings, %0d results, %0d with faults.",
         sent, seen_results, seen_faults);
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #(60_000_000);
      $display("Mismatches found");
      $finish;
   end

endmodule

FILE: filelist.f
design/tsre_pkg.sv
design/tsre_if.sv
design/tsre_div.sv
design/thrust_slope_rls_estimator_unit.sv
dv/thrust_slope_rls_estimator_unit_checker.sv
dv/thrust_slope_rls_estimator_unit_tb.sv
